// ----- rtl/stms_pkg.sv -----
// Shared constants, types and register codes of the trimmed-mean smoother.
package stms_pkg;

	localparam int WINDOW      = 5;
	localparam int CHANNELS    = 5;
	localparam int NUM_SAMPLES = 5;
	localparam int TRIM_TAPS   = 3;
	localparam int SAMPLE_W    = 12;
	localparam int CH_W        = 3;
	localparam int PCT_W       = 10;
	localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;

	localparam int TRIM_W  = $clog2(TRIM_TAPS * SAMPLE_MAX + 1);
	localparam int DIV     = TRIM_TAPS * WINDOW;
	localparam int SUM_W   = $clog2(DIV * SAMPLE_MAX + 1);
	localparam int PCT_SCALE = 100;
	localparam int NUM_W   = $clog2(PCT_SCALE * DIV * SAMPLE_MAX + 1);
	localparam int QW      = SAMPLE_W;
	localparam int CNT_W   = $clog2(QW + 1);
	localparam int CMP_W   = (NUM_W > SUM_W + QW) ? NUM_W : SUM_W + QW;

	// floor(sum / DIV) as (sum * SMO_RECIP) >> SMO_SHIFT, exact over the sum range
	localparam int SMO_SHIFT  = SUM_W + $clog2(DIV);
	localparam int RECIP_W    = SUM_W + 1;
	localparam int SMO_RECIP  = ((1 << SMO_SHIFT) + DIV - 1) / DIV;
	localparam int SMO_PROD_W = SUM_W + RECIP_W;

	localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int HEAD_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int LANE_IDX_W = $clog2(NUM_SAMPLES);

	localparam logic [CH_W-1:0] SLOPE_CH = 3'd4;

	localparam int LEVEL_MIN = 1;
	localparam int LEVEL_MAX = 100;
	localparam int SLOPE_SAT = 1000;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL_CH0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL     = 3'd5;
	localparam int NUM_MAX_REGS = 5;

	typedef logic [NUM_SAMPLES-1:0][SAMPLE_W-1:0] sample_vec_t;

	typedef struct packed {
		logic is_min;
		logic is_max;
	} lane_flags_t;

endpackage

// ----- rtl/sensor_trimmed_mean_smoother.sv -----
// Top level of the trimmed-mean smoother with min/max level normalization.
//
// Each input beat carries five 12-bit samples of one sensor channel. Five
// parallel lanes flag the lowest and highest sample (first equal sample wins
// the minimum, last equal sample the maximum), and a merge stage sums the
// remaining three into the trimmed sum as the beat is accepted. The trimmed
// sum replaces the oldest entry of that channel's circular window (WINDOW
// entries per channel, held in flip-flops cleared by reset) and the running
// window total is updated. smoothed_value is floor(total / (3*WINDOW)).
// Channels 0-3 report level_percent = floor(100*(avg-min)/(max-min)),
// clamped to 1..100; channel 4 reports the slope percent of the current
// trimmed mean, 0 when not positive and saturated at 1000. When a channel's
// max_level is not above min_level, calib_error is set and level_percent is
// 0 (the window is still updated). A channel above 4 changes no state and
// returns zeros with the channel echoed. The smoothed value comes from a
// reciprocal multiply by the constant 1/(3*WINDOW); the percent comes from a
// 12-step restoring divider. An accepted beat passes through ST_UPD, ST_PREP,
// ST_MUL and ST_DIV to ST_OUT; a channel that is out of range goes from
// ST_UPD straight to ST_OUT. One beat is in work at a time; in_ready rises
// again once the result sits in the output register, so the next beat can
// be taken while that result waits for out_ready. Configuration is a plain
// write port (index 0-4: max_level_ch0..4, index 5: min_level, others
// ignored); the user writes it only while the block is idle, which the
// block itself does not enforce.
module sensor_trimmed_mean_smoother (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [stms_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [stms_pkg::SAMPLE_W-1:0]     cfg_wdata,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [stms_pkg::CH_W-1:0]         channel,
	input  logic [stms_pkg::SAMPLE_W-1:0]     sample_a,
	input  logic [stms_pkg::SAMPLE_W-1:0]     sample_b,
	input  logic [stms_pkg::SAMPLE_W-1:0]     sample_c,
	input  logic [stms_pkg::SAMPLE_W-1:0]     sample_d,
	input  logic [stms_pkg::SAMPLE_W-1:0]     sample_e,
	// output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [stms_pkg::CH_W-1:0]         channel_out,
	output logic [stms_pkg::SAMPLE_W-1:0]     smoothed_value,
	output logic [stms_pkg::PCT_W-1:0]        level_percent,
	output logic                              calib_error
);
	import stms_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t state_q;

	// ---------------- configuration registers ----------------
	logic [SAMPLE_W-1:0] max_level_q [NUM_MAX_REGS];
	logic [SAMPLE_W-1:0] min_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MAX_REGS; i++) max_level_q[i] <= SAMPLE_W'(SAMPLE_MAX);
			min_level_q <= SAMPLE_W'(5);
		end else if (cfg_we) begin
			if (cfg_index < REG_MIN_LEVEL) begin
				max_level_q[cfg_index] <= cfg_wdata;
			end else if (cfg_index == REG_MIN_LEVEL) begin
				min_level_q <= cfg_wdata;
			end
		end
	end

	// ---------------- sample lanes and merge ----------------
	sample_vec_t smp;
	lane_flags_t flags [NUM_SAMPLES];
	logic [TRIM_W-1:0] trim_sum;

	assign smp = {sample_e, sample_d, sample_c, sample_b, sample_a};

	for (genvar g = 0; g < NUM_SAMPLES; g++) begin : g_lane
		stms_lane u_lane (
			.smp   (smp),
			.idx   (LANE_IDX_W'(g)),
			.flags (flags[g])
		);
	end

	always_comb begin
		trim_sum = '0;
		for (int i = 0; i < NUM_SAMPLES; i++) begin
			if (!flags[i].is_min && !flags[i].is_max) trim_sum = trim_sum + TRIM_W'(smp[i]);
		end
	end

	// ---------------- item registers ----------------
	logic [CH_W-1:0]     ch_q;
	logic [TRIM_W-1:0]   trim_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] mx_q;
	logic                err_q;
	logic                nonpos_q;
	logic [SUM_W-1:0]    diff_q;
	logic [SUM_W-1:0]    den_q;
	logic                sat_q;
	logic [SAMPLE_W-1:0] smo_q;

	logic              ch_ok;
	logic              is_slope;
	logic [CH_IDX_W-1:0] ci;

	assign ch_ok    = (ch_q < CH_W'(CHANNELS)) && (ch_q <= SLOPE_CH);
	assign is_slope = (ch_q == SLOPE_CH);
	assign ci       = ch_q[CH_IDX_W-1:0];

	// ---------------- window store ----------------
	logic [TRIM_W-1:0] store_q [CHANNELS][WINDOW];
	logic [HEAD_W-1:0] head_q  [CHANNELS];
	logic [SUM_W-1:0]  sums_q  [CHANNELS];
	logic [TRIM_W-1:0] oldest;
	logic [SUM_W-1:0]  new_sum;
	logic              win_upd;

	assign oldest  = store_q[ci][head_q[ci]];
	assign new_sum = sums_q[ci] - SUM_W'(oldest) + SUM_W'(trim_q);
	assign win_upd = (state_q == ST_UPD) && ch_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				head_q[c] <= '0;
				sums_q[c] <= '0;
				for (int w = 0; w < WINDOW; w++) store_q[c][w] <= '0;
			end
		end else if (win_upd) begin
			store_q[ci][head_q[ci]] <= trim_q;
			sums_q[ci] <= new_sum;
			head_q[ci] <= (head_q[ci] == HEAD_W'(WINDOW - 1)) ? '0 : head_q[ci] + 1'b1;
		end
	end

	// ---------------- numerator / denominator prep ----------------
	logic [SUM_W-1:0] mul_k;
	logic [SUM_W-1:0] base;
	logic [SUM_W-1:0] value;
	logic [NUM_W-1:0] num100;
	logic             sat;
	logic [SMO_PROD_W-1:0] smo_prod;

	assign mul_k  = is_slope ? SUM_W'(TRIM_TAPS) : SUM_W'(DIV);
	assign base   = mul_k * SUM_W'(min_level_q);
	assign value  = is_slope ? SUM_W'(trim_q) : sum_q;
	assign num100 = NUM_W'(diff_q) * NUM_W'(PCT_SCALE);
	assign sat    = CMP_W'(num100) >= (CMP_W'(den_q) << QW);

	// window total times the reciprocal of 3*WINDOW; the quotient sits above SMO_SHIFT
	assign smo_prod = SMO_PROD_W'(sum_q) * SMO_PROD_W'(SMO_RECIP);

	// ---------------- divider ----------------
	logic          div_start;
	logic          pct_done;
	logic [QW-1:0] pct_quot;

	assign div_start = (state_q == ST_MUL);

	stms_div u_div_pct (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num100),
		.den    (den_q),
		.done   (pct_done),
		.quot   (pct_quot)
	);

	// ---------------- result selection ----------------
	logic [PCT_W-1:0]    pct_res;
	logic [SAMPLE_W-1:0] smo_res;

	always_comb begin
		smo_res = smo_q;
		if (err_q) begin
			pct_res = '0;
		end else if (is_slope) begin
			if (nonpos_q)                                    pct_res = '0;
			else if (sat_q || pct_quot > QW'(SLOPE_SAT))     pct_res = PCT_W'(SLOPE_SAT);
			else                                             pct_res = pct_quot[PCT_W-1:0];
		end else begin
			if (nonpos_q)                                    pct_res = PCT_W'(LEVEL_MIN);
			else if (sat_q || pct_quot > QW'(LEVEL_MAX))     pct_res = PCT_W'(LEVEL_MAX);
			else if (pct_quot < QW'(LEVEL_MIN))              pct_res = PCT_W'(LEVEL_MIN);
			else                                             pct_res = pct_quot[PCT_W-1:0];
		end
		if (!ch_ok) begin
			pct_res = '0;
			smo_res = '0;
		end
	end

	// ---------------- control ----------------
	logic                out_valid_q;
	logic [CH_W-1:0]     channel_out_q;
	logic [SAMPLE_W-1:0] smoothed_q;
	logic [PCT_W-1:0]    percent_q;
	logic                calib_err_q;
	logic                out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one taken in the same cycle
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ch_ok ? ST_PREP : ST_OUT;
				end
				ST_PREP: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (pct_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, loaded as the item moves through the states
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			ch_q   <= channel;
			trim_q <= trim_sum;
		end
		if (state_q == ST_UPD) begin
			sum_q <= new_sum;
			mx_q  <= max_level_q[ch_q];
		end
		if (state_q == ST_PREP) begin
			err_q    <= (mx_q <= min_level_q);
			nonpos_q <= (value <= base);
			diff_q   <= value - base;
			den_q    <= mul_k * SUM_W'(mx_q - min_level_q);
			smo_q    <= smo_prod[SMO_SHIFT +: SAMPLE_W];
		end
		if (state_q == ST_MUL) begin
			sat_q <= sat;
		end
		if (state_q == ST_OUT && out_free) begin
			channel_out_q <= ch_q;
			smoothed_q    <= smo_res;
			percent_q     <= pct_res;
			calib_err_q   <= ch_ok && err_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign channel_out    = channel_out_q;
	assign smoothed_value = smoothed_q;
	assign level_percent  = percent_q;
	assign calib_error    = calib_err_q;

endmodule

// ----- rtl/stms_lane.sv -----
// One sample lane: decides whether its sample is the dropped minimum or maximum.
module stms_lane (
	input  stms_pkg::sample_vec_t              smp,
	input  logic [stms_pkg::LANE_IDX_W-1:0]    idx,
	output stms_pkg::lane_flags_t              flags
);
	import stms_pkg::*;

	logic [SAMPLE_W-1:0] own;

	assign own = smp[idx];

	// ties: min goes to the first equal lane, max to the last one
	always_comb begin
		flags.is_min = 1'b1;
		flags.is_max = 1'b1;
		for (int j = 0; j < NUM_SAMPLES; j++) begin
			if (LANE_IDX_W'(j) < idx) begin
				if (!(own < smp[j]))  flags.is_min = 1'b0;
				if (!(own >= smp[j])) flags.is_max = 1'b0;
			end else if (LANE_IDX_W'(j) > idx) begin
				if (!(own <= smp[j])) flags.is_min = 1'b0;
				if (!(own > smp[j]))  flags.is_max = 1'b0;
			end
		end
	end

endmodule

// ----- rtl/stms_div.sv -----
// Restoring divider, one quotient bit per cycle; quotient must fit in QW bits.
module stms_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [stms_pkg::NUM_W-1:0]    num,
	input  logic [stms_pkg::SUM_W-1:0]    den,
	output logic                          done,
	output logic [stms_pkg::QW-1:0]       quot
);
	import stms_pkg::*;

	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] den_q;
	logic [QW-1:0]    numlo_q;
	logic [QW-1:0]    quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [SUM_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, numlo_q[QW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(QW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= SUM_W'(num >> QW);
			numlo_q <= num[QW-1:0];
			den_q   <= den;
			quot_q  <= '0;
		end else if (run_q) begin
			rem_q   <= fits ? SUM_W'(trial - {1'b0, den_q}) : SUM_W'(trial);
			numlo_q <= numlo_q << 1;
			quot_q  <= {quot_q[QW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
